>>> hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Expression must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/lped_pkg.sv
package lped_pkg;

   // Field widths fixed by the transaction formats
   localparam int POWER_W    = 24;
   localparam int TIME_W     = 32;
   localparam int ALPHA_W    = 16;
   localparam int Q16_W      = ALPHA_W + 1;
   localparam int CNT_W      = 8;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // Defaults for the top-level parameters
   localparam int POWER_BITS_DEF         = 24;
   localparam int BASELINE_ALPHA_Q16_DEF = 62259;

   // Entries in the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FILTER_ALPHA       = 4'd0,
      CSR_ON_ABS_THRESHOLD   = 4'd1,
      CSR_OFF_ABS_THRESHOLD  = 4'd2,
      CSR_ON_REL_OFFSET      = 4'd3,
      CSR_OFF_REL_OFFSET     = 4'd4,
      CSR_ON_DEBOUNCE_COUNT  = 4'd5,
      CSR_OFF_DEBOUNCE_COUNT = 4'd6,
      CSR_COOLDOWN_MS        = 4'd7
   } csr_idx_type;

   typedef struct packed {
      logic [ALPHA_W-1:0] filter_alpha;
      logic [POWER_W-1:0] on_abs_threshold;
      logic [POWER_W-1:0] off_abs_threshold;
      logic [POWER_W-1:0] on_rel_offset;
      logic [POWER_W-1:0] off_rel_offset;
      logic [CNT_W-1:0]   on_debounce_count;
      logic [CNT_W-1:0]   off_debounce_count;
      logic [TIME_W-1:0]  cooldown_ms;
   } cfg_type;

   localparam cfg_type CFG_RST = '{
      filter_alpha:       16'd52429,
      on_abs_threshold:   24'd1280,
      off_abs_threshold:  24'd512,
      on_rel_offset:      24'd1536,
      off_rel_offset:     24'd768,
      on_debounce_count:  8'd5,
      off_debounce_count: 8'd15,
      cooldown_ms:        32'd8000
   };

   // One classified sample as it waits in the queue
   typedef struct packed {
      logic               closed;
      logic [TIME_W-1:0]  now_ms;
      logic [POWER_W-1:0] power;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_head_type;

endpackage

>>> hw/rtl/lped_req_if.sv
interface lped_req_if import lped_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               socket_closed;
   logic [POWER_W-1:0] power_sample;
   logic [TIME_W-1:0]  now_ms;

   modport source (output valid, output socket_closed, output power_sample, output now_ms,
                   input ready);
   modport sink (input valid, input socket_closed, input power_sample, input now_ms,
                 output ready);
endinterface

>>> hw/rtl/lped_rsp_if.sv
interface lped_rsp_if import lped_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               trigger;
   logic               load_on;
   logic [POWER_W-1:0] filtered_power;
   logic [POWER_W-1:0] baseline_power;

   modport source (output valid, output trigger, output load_on, output filtered_power,
                   output baseline_power, input ready);
   modport sink (input valid, input trigger, input load_on, input filtered_power,
                 input baseline_power, output ready);
endinterface

>>> hw/rtl/lped_csr_if.sv
interface lped_csr_if import lped_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] wdata;

   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface

>>> hw/rtl/lped_csr.sv
module lped_csr import lped_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   lped_csr_if.sink csr,
   output cfg_type cfg
);

   cfg_type cfg_ff;

   // Writes are always taken
   assign csr.ready = 1'b1;
   assign cfg       = cfg_ff;

   // Update the addressed register; drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RST;
      end else if (csr.valid) begin
         case (csr_idx_type'(csr.index))
            CSR_FILTER_ALPHA:       cfg_ff.filter_alpha       <= csr.wdata[ALPHA_W-1:0];
            CSR_ON_ABS_THRESHOLD:   cfg_ff.on_abs_threshold   <= csr.wdata[POWER_W-1:0];
            CSR_OFF_ABS_THRESHOLD:  cfg_ff.off_abs_threshold  <= csr.wdata[POWER_W-1:0];
            CSR_ON_REL_OFFSET:      cfg_ff.on_rel_offset      <= csr.wdata[POWER_W-1:0];
            CSR_OFF_REL_OFFSET:     cfg_ff.off_rel_offset     <= csr.wdata[POWER_W-1:0];
            CSR_ON_DEBOUNCE_COUNT:  cfg_ff.on_debounce_count  <= csr.wdata[CNT_W-1:0];
            CSR_OFF_DEBOUNCE_COUNT: cfg_ff.off_debounce_count <= csr.wdata[CNT_W-1:0];
            CSR_COOLDOWN_MS:        cfg_ff.cooldown_ms        <= csr.wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

endmodule

>>> hw/rtl/lped_front.sv
`include "assert_macros.svh"

module lped_front import lped_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   lped_req_if.sink   req,
   output q_head_type head,
   input  logic       pop
);

   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [QCNT_W-1:0] QFULL    = QCNT_W'(QUEUE_DEPTH);
   localparam logic [QPTR_W-1:0] QPTR_MAX = QPTR_W'(QUEUE_DEPTH - 1);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   item_type          item_in;
   logic              push;

   // Classify: an open relay carries no power into the filter
   always_comb begin
      item_in.closed = req.socket_closed;
      item_in.now_ms = req.now_ms;
      item_in.power  = req.socket_closed ? req.power_sample : '0;
   end

   assign req.ready  = (count_ff != QFULL);
   assign push       = req.valid && req.ready;
   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   // Store the accepted transaction
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= item_in;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_MAX) ? '0 : wr_ptr_ff + QPTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_MAX) ? '0 : rd_ptr_ff + QPTR_W'(1);
         end
         case ({push, pop})
            2'b10:   count_ff <= count_ff + QCNT_W'(1);
            2'b01:   count_ff <= count_ff - QCNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   `ASSERT_ALWAYS(a_queue_bound, clock, reset, count_ff <= QFULL, "queue overfilled")
   `ASSERT_IMPLY(a_pop_nonempty, clock, reset, pop, head.valid, "pop from empty queue")

endmodule

>>> hw/rtl/lped_back.sv
`include "assert_macros.svh"

module lped_back import lped_pkg::*; #(
   parameter int POWER_BITS         = POWER_BITS_DEF,
   parameter int BASELINE_ALPHA_Q16 = BASELINE_ALPHA_Q16_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  q_head_type head,
   output logic       pop,
   lped_rsp_if.source rsp
);

   localparam int PW    = POWER_BITS;
   localparam int PRODW = PW + Q16_W;
   localparam int TW    = ((PW > POWER_W) ? PW : POWER_W) + 1;
   localparam logic [Q16_W-1:0] Q16_ONE    = Q16_W'(65536);
   localparam logic [Q16_W-1:0] BASE_OLD_W = Q16_W'(BASELINE_ALPHA_Q16);
   localparam logic [Q16_W-1:0] BASE_NEW_W = Q16_ONE - BASE_OLD_W;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILT_NEW,
      ST_BASE_OLD,
      ST_BASE_NEW,
      ST_DECIDE
   } state_type;

   state_type          state_ff;
   logic [PRODW-1:0]   acc_ff;
   logic [PW-1:0]      filter_ff;
   logic [PW-1:0]      baseline_ff;
   logic               on_state_ff;
   logic [CNT_W-1:0]   on_cnt_ff;
   logic [CNT_W-1:0]   off_cnt_ff;
   logic [TIME_W-1:0]  last_trig_ff;
   logic               has_trig_ff;
   logic               rsp_valid_ff;
   logic               rsp_trig_ff;
   logic               rsp_load_on_ff;
   logic [POWER_W-1:0] rsp_filtered_ff;
   logic [POWER_W-1:0] rsp_baseline_ff;

   logic               on_state_in;
   logic [CNT_W-1:0]   on_cnt_in;
   logic [CNT_W-1:0]   off_cnt_in;
   logic [TIME_W-1:0]  last_trig_in;
   logic               has_trig_in;
   logic               trig_in;

   logic [POWER_W+PW-1:0] p_wide;
   logic [PW-1:0]         p_val;
   logic [Q16_W-1:0]      mul_a;
   logic [PW-1:0]         mul_b;
   logic [PRODW-1:0]      product;
   logic [PRODW-1:0]      acc_sum;
   logic [PW-1:0]         blend;
   logic [TW-1:0]         f_t;
   logic [TW-1:0]         b_t;
   logic [TW-1:0]         on_sum;
   logic [TW-1:0]         off_sum;
   logic [TW-1:0]         on_th;
   logic [TW-1:0]         off_th;
   logic [TW-1:0]         on_abs_t;
   logic [TW-1:0]         off_abs_t;
   logic [TIME_W-1:0]     elapsed;
   logic                  cool_ok;
   logic [CNT_W-1:0]      on_n;
   logic [CNT_W-1:0]      off_n;
   logic                  rsp_free;
   logic [PW+POWER_W-1:0] f_wide;
   logic [PW+POWER_W-1:0] b_wide;

   // Fit the sample to the internal power width
   assign p_wide = {{PW{1'b0}}, head.item.power};
   assign p_val  = p_wide[PW-1:0];

   // Select operands of the shared multiply-accumulate
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_IDLE: begin
            mul_a = {1'b0, cfg.filter_alpha};
            mul_b = filter_ff;
         end
         ST_FILT_NEW: begin
            mul_a = Q16_ONE - {1'b0, cfg.filter_alpha};
            mul_b = p_val;
         end
         ST_BASE_OLD: begin
            mul_a = BASE_OLD_W;
            mul_b = baseline_ff;
         end
         ST_BASE_NEW: begin
            mul_a = BASE_NEW_W;
            mul_b = head.item.closed ? filter_ff : '0;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // The weighted sum never exceeds 2^16 times the largest power value
   assign product = PRODW'(mul_a) * PRODW'(mul_b);
   assign acc_sum = acc_ff + product;
   assign blend   = acc_sum[PW+ALPHA_W-1:ALPHA_W];

   // Thresholds one bit wider than either operand so the offset sum cannot wrap
   assign f_t       = TW'(filter_ff);
   assign b_t       = TW'(baseline_ff);
   assign on_abs_t  = TW'(cfg.on_abs_threshold);
   assign off_abs_t = TW'(cfg.off_abs_threshold);
   assign on_sum    = b_t + TW'(cfg.on_rel_offset);
   assign off_sum   = b_t + TW'(cfg.off_rel_offset);
   assign on_th     = (on_abs_t > on_sum) ? on_abs_t : on_sum;
   assign off_th    = (off_abs_t > off_sum) ? off_abs_t : off_sum;

   // Cooldown on wrapping millisecond time
   assign elapsed = head.item.now_ms - last_trig_ff;
   assign cool_ok = !has_trig_ff || (elapsed >= cfg.cooldown_ms);

   // Counters stay at or below 254, so the increment never wraps
   assign on_n  = on_cnt_ff + CNT_W'(1);
   assign off_n = off_cnt_ff + CNT_W'(1);

   // Debounce and hysteresis decision
   always_comb begin
      on_state_in  = on_state_ff;
      on_cnt_in    = on_cnt_ff;
      off_cnt_in   = off_cnt_ff;
      last_trig_in = last_trig_ff;
      has_trig_in  = has_trig_ff;
      trig_in      = 1'b0;
      if (!head.item.closed) begin
         on_state_in = 1'b0;
         on_cnt_in   = '0;
         off_cnt_in  = '0;
      end else if (!on_state_ff) begin
         if (f_t > on_th) begin
            if (on_n >= cfg.on_debounce_count) begin
               on_cnt_in  = '0;
               off_cnt_in = '0;
               if (cool_ok) begin
                  last_trig_in = head.item.now_ms;
                  has_trig_in  = 1'b1;
                  on_state_in  = 1'b1;
                  trig_in      = 1'b1;
               end
            end else begin
               on_cnt_in = on_n;
            end
         end else begin
            on_cnt_in = '0;
         end
      end else begin
         if (f_t < off_th) begin
            if (off_n >= cfg.off_debounce_count) begin
               off_cnt_in  = '0;
               on_cnt_in   = '0;
               on_state_in = 1'b0;
            end else begin
               off_cnt_in = off_n;
            end
         end else begin
            off_cnt_in = '0;
         end
      end
   end

   assign rsp_free = !rsp_valid_ff || rsp.ready;
   assign pop      = (state_ff == ST_DECIDE) && rsp_free;

   assign f_wide = {{POWER_W{1'b0}}, filter_ff};
   assign b_wide = {{POWER_W{1'b0}}, baseline_ff};

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.trigger        = rsp_trig_ff;
   assign rsp.load_on        = rsp_load_on_ff;
   assign rsp.filtered_power = rsp_filtered_ff;
   assign rsp.baseline_power = rsp_baseline_ff;

   // Sequence the four products, then decide and publish the result
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         acc_ff          <= '0;
         filter_ff       <= '0;
         baseline_ff     <= '0;
         on_state_ff     <= 1'b0;
         on_cnt_ff       <= '0;
         off_cnt_ff      <= '0;
         last_trig_ff    <= '0;
         has_trig_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rsp_trig_ff     <= 1'b0;
         rsp_load_on_ff  <= 1'b0;
         rsp_filtered_ff <= '0;
         rsp_baseline_ff <= '0;
      end else begin
         // Drop the result once taken, unless a new one loads in this cycle
         if (rsp.ready && !pop) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (head.valid) begin
                  acc_ff   <= product;
                  state_ff <= ST_FILT_NEW;
               end
            end
            ST_FILT_NEW: begin
               filter_ff <= blend;
               state_ff  <= ST_BASE_OLD;
            end
            ST_BASE_OLD: begin
               acc_ff   <= product;
               state_ff <= ST_BASE_NEW;
            end
            ST_BASE_NEW: begin
               // Baseline adapts only while OFF, and decays with the relay open
               if (!head.item.closed || !on_state_ff) begin
                  baseline_ff <= blend;
               end
               state_ff <= ST_DECIDE;
            end
            ST_DECIDE: begin
               if (rsp_free) begin
                  on_state_ff     <= on_state_in;
                  on_cnt_ff       <= on_cnt_in;
                  off_cnt_ff      <= off_cnt_in;
                  last_trig_ff    <= last_trig_in;
                  has_trig_ff     <= has_trig_in;
                  rsp_valid_ff    <= 1'b1;
                  rsp_trig_ff     <= trig_in;
                  rsp_load_on_ff  <= on_state_in;
                  rsp_filtered_ff <= f_wide[POWER_W-1:0];
                  rsp_baseline_ff <= b_wide[POWER_W-1:0];
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   `ASSERT_IMPLY(a_off_cnt_when_off, clock, reset, !on_state_ff, off_cnt_ff == '0, "off count in OFF")
   `ASSERT_IMPLY(a_on_cnt_when_on, clock, reset, on_state_ff, on_cnt_ff == '0, "on count in ON")
   `ASSERT_IMPLY(a_trig_is_on, clock, reset, rsp_valid_ff && rsp_trig_ff, rsp_load_on_ff && has_trig_ff, "trigger without ON")
   `ASSERT_NEXT(a_decide_hold, clock, reset, (state_ff == ST_DECIDE) && !rsp_free, (state_ff == ST_DECIDE) && $stable(filter_ff) && $stable(on_state_ff), "decision moved while output stalled")

endmodule

>>> hw/rtl/load_power_event_detector.sv
// Channel    Role       Payload
// req_chan   sink       socket_closed, power_sample, now_ms
// rsp_chan   source     trigger, load_on, filtered_power, baseline_power
// csr_chan   sink       index, wdata (register write, always ready)
//
// Each transaction in the back end makes four passes through the one
// 17 x POWER_BITS multiply-accumulate (filter old, filter new, baseline old,
// baseline new) and then enters a decision state that loads the output register.
// A two-entry queue lets req_chan keep accepting while the back end works or
// rsp_chan stalls; a stalled result holds the back end in its decision cycle.
// Synchronous reset loads register defaults and clears detector state.
module load_power_event_detector import lped_pkg::*; #(
   parameter int POWER_BITS         = POWER_BITS_DEF,
   parameter int BASELINE_ALPHA_Q16 = BASELINE_ALPHA_Q16_DEF
) (
   input logic        clock,
   input logic        reset,
   lped_req_if.sink   req_chan,
   lped_rsp_if.source rsp_chan,
   lped_csr_if.sink   csr_chan
);

   cfg_type    cfg;
   q_head_type head;
   logic       pop;

   lped_csr u_csr (
      .clock (clock),
      .reset (reset),
      .csr   (csr_chan),
      .cfg   (cfg)
   );

   lped_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .head  (head),
      .pop   (pop)
   );

   lped_back #(
      .POWER_BITS         (POWER_BITS),
      .BASELINE_ALPHA_Q16 (BASELINE_ALPHA_Q16)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule
